/* rtl/ima_adpcm_block_decoder_defines.svh */
// Assertion macros for the IMA ADPCM block decoder checker.
// Needs signals named clk and rst_n in the scope where a macro is used.
`ifndef IMA_ADPCM_BLOCK_DECODER_DEFINES_SVH
`define IMA_ADPCM_BLOCK_DECODER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IMADEC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define IMADEC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/imadec_pkg.sv */
// Shared types, constants and tables of the IMA ADPCM block decoder.
// No dependencies; used by imadec_nibble, imadec_outbuf and the top level.
package imadec_pkg;

    localparam logic [6:0]  MAX_STEP_INDEX  = 7'd88;
    localparam logic [1:0]  CHANNELS_STEREO = 2'd2;
    localparam logic [15:0] HDR_LEN_MONO    = 16'd4;
    localparam logic [15:0] HDR_LEN_STEREO  = 16'd8;
    localparam logic [15:0] SAMPLE_MAX      = 16'h7FFF;
    localparam logic [15:0] SAMPLE_MIN      = 16'h8000;

    // configuration register indexes
    localparam logic REG_CHANNEL_COUNT = 1'b0;
    localparam logic REG_BLOCK_ALIGN   = 1'b1;

    typedef struct packed {
        logic signed [15:0] pcm_sample;
        logic               sample_channel;
        logic               run_last;
    } out_item_t;

    typedef struct packed {
        logic       load;
        logic [2:0] count;
    } buf_load_t;

    function automatic logic signed [4:0] index_adjust(input logic [2:0] mag);
        logic signed [4:0] adj;
        case (mag)
            3'd4:    adj = 5'sd2;
            3'd5:    adj = 5'sd4;
            3'd6:    adj = 5'sd6;
            3'd7:    adj = 5'sd8;
            default: adj = -5'sd1;
        endcase
        return adj;
    endfunction

    function automatic logic [14:0] step_size(input logic [6:0] idx);
        logic [14:0] s;
        case (idx)
            7'd0:  s = 15'd7;     7'd1:  s = 15'd8;     7'd2:  s = 15'd9;
            7'd3:  s = 15'd10;    7'd4:  s = 15'd11;    7'd5:  s = 15'd12;
            7'd6:  s = 15'd13;    7'd7:  s = 15'd14;    7'd8:  s = 15'd16;
            7'd9:  s = 15'd17;    7'd10: s = 15'd19;    7'd11: s = 15'd21;
            7'd12: s = 15'd23;    7'd13: s = 15'd25;    7'd14: s = 15'd28;
            7'd15: s = 15'd31;    7'd16: s = 15'd34;    7'd17: s = 15'd37;
            7'd18: s = 15'd41;    7'd19: s = 15'd45;    7'd20: s = 15'd50;
            7'd21: s = 15'd55;    7'd22: s = 15'd60;    7'd23: s = 15'd66;
            7'd24: s = 15'd73;    7'd25: s = 15'd80;    7'd26: s = 15'd88;
            7'd27: s = 15'd97;    7'd28: s = 15'd107;   7'd29: s = 15'd118;
            7'd30: s = 15'd130;   7'd31: s = 15'd143;   7'd32: s = 15'd157;
            7'd33: s = 15'd173;   7'd34: s = 15'd190;   7'd35: s = 15'd209;
            7'd36: s = 15'd230;   7'd37: s = 15'd253;   7'd38: s = 15'd279;
            7'd39: s = 15'd307;   7'd40: s = 15'd337;   7'd41: s = 15'd371;
            7'd42: s = 15'd408;   7'd43: s = 15'd449;   7'd44: s = 15'd494;
            7'd45: s = 15'd544;   7'd46: s = 15'd598;   7'd47: s = 15'd658;
            7'd48: s = 15'd724;   7'd49: s = 15'd796;   7'd50: s = 15'd876;
            7'd51: s = 15'd963;   7'd52: s = 15'd1060;  7'd53: s = 15'd1166;
            7'd54: s = 15'd1282;  7'd55: s = 15'd1411;  7'd56: s = 15'd1552;
            7'd57: s = 15'd1707;  7'd58: s = 15'd1878;  7'd59: s = 15'd2066;
            7'd60: s = 15'd2272;  7'd61: s = 15'd2499;  7'd62: s = 15'd2749;
            7'd63: s = 15'd3024;  7'd64: s = 15'd3327;  7'd65: s = 15'd3660;
            7'd66: s = 15'd4026;  7'd67: s = 15'd4428;  7'd68: s = 15'd4871;
            7'd69: s = 15'd5358;  7'd70: s = 15'd5894;  7'd71: s = 15'd6484;
            7'd72: s = 15'd7132;  7'd73: s = 15'd7845;  7'd74: s = 15'd8630;
            7'd75: s = 15'd9493;  7'd76: s = 15'd10442; 7'd77: s = 15'd11487;
            7'd78: s = 15'd12635; 7'd79: s = 15'd13899; 7'd80: s = 15'd15289;
            7'd81: s = 15'd16818; 7'd82: s = 15'd18500; 7'd83: s = 15'd20350;
            7'd84: s = 15'd22385; 7'd85: s = 15'd24623; 7'd86: s = 15'd27086;
            7'd87: s = 15'd29794;
            default: s = 15'd32767;
        endcase
        return s;
    endfunction

endpackage

/* rtl/imadec_nibble.sv */
// One-nibble IMA ADPCM decode step: predictor and step index in, updated pair out.
// Depends on imadec_pkg (step table, index adjust, limits).
module imadec_nibble
(
    input  logic signed [15:0] pred_in,
    input  logic [6:0]         idx_in,
    input  logic [3:0]         nib,
    output logic signed [15:0] pred_out,
    output logic [6:0]         idx_out
);

    logic [6:0]         idx;
    logic [14:0]        step;
    logic [18:0]        prod;
    logic [15:0]        diff;
    logic signed [17:0] sum;
    logic signed [7:0]  pos;

    always_comb
    begin
        idx  = (idx_in > imadec_pkg::MAX_STEP_INDEX) ? imadec_pkg::MAX_STEP_INDEX : idx_in;
        step = imadec_pkg::step_size(idx);
        // (2m+1)*step, then drop three fraction bits
        prod = {15'd0, nib[2:0], 1'b1} * {4'd0, step};
        diff = prod[18:3];
        if (nib[3])
            sum = {{2{pred_in[15]}}, pred_in} - $signed({2'b00, diff});
        else
            sum = {{2{pred_in[15]}}, pred_in} + $signed({2'b00, diff});

        // saturate to 16 bits
        if (sum[17] && !(sum[16] && sum[15]))
            pred_out = $signed(imadec_pkg::SAMPLE_MIN);
        else if (!sum[17] && (sum[16] || sum[15]))
            pred_out = $signed(imadec_pkg::SAMPLE_MAX);
        else
            pred_out = sum[15:0];

        pos = $signed({1'b0, idx}) + 8'(imadec_pkg::index_adjust(nib[2:0]));
        if (pos[7])
            idx_out = 7'd0;
        else if (pos[6:0] > imadec_pkg::MAX_STEP_INDEX)
            idx_out = imadec_pkg::MAX_STEP_INDEX;
        else
            idx_out = pos[6:0];
    end

endmodule

/* rtl/imadec_outbuf.sv */
// Four-word result buffer: loads up to four words at once, drains one per cycle while out_ready is high.
// Depends on imadec_pkg (out_item_t, buf_load_t).
module imadec_outbuf
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  imadec_pkg::buf_load_t        ctrl,
    input  imadec_pkg::out_item_t [3:0]  load_items,
    output logic                         can_load,
    output logic                         out_valid,
    input  logic                         out_ready,
    output imadec_pkg::out_item_t        out_item
);

    logic [2:0]                  count_reg;
    logic [2:0]                  count_next;
    imadec_pkg::out_item_t [3:0] entry_reg;
    logic                        drain;

    assign out_valid = (count_reg != 3'd0);
    assign out_item  = entry_reg[0];
    assign drain     = out_valid && out_ready;
    // free now, or the last word leaves this cycle
    assign can_load  = (count_reg == 3'd0) || ((count_reg == 3'd1) && out_ready);

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.load)
            count_next = ctrl.count;
        else if (drain)
            count_next = count_reg - 3'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 3'd0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
            entry_reg <= load_items;
        else if (drain)
            entry_reg <= {entry_reg[3], entry_reg[3:1]};
    end

endmodule

/* rtl/ima_adpcm_block_decoder.sv */
// Top level of the IMA ADPCM block decoder: input register, decoder state, left buffer.
// Depends on imadec_pkg, imadec_nibble and imadec_outbuf.

// Decodes the data-chunk bytes of a block-structured 4-bit IMA ADPCM stream, mono or
// stereo, one byte per input word, into signed 16-bit samples, one per output word.
// Each block opens with a 4-byte header per channel (little-endian predictor, then step
// index clamped to 0..88); header bytes give no samples. A mono data byte gives two
// samples, low nibble first. In stereo, four left bytes are decoded into a small left
// buffer and each of the next four right bytes gives left, right, left, right. tlast on
// the input ends a chunk and restarts the block position; tlast on the output marks the
// last sample of an input byte, tuser carries the channel (0 left or mono, 1 right).
// Timing: an input byte is taken into an input register and decoded from there (both
// nibbles in one pass) once the four-word result buffer can take its samples, which
// are then loaded into that buffer; its head word is offered on the output. The buffer
// drains one sample per cycle while m_axis_tready is high, so a mono data byte holds
// the output for its two samples and a stereo right byte for its four; header and
// stereo left bytes give no samples and never wait on the buffer. The input accepts a
// new byte while earlier samples still wait, as long as the input register is free or
// moves on that cycle. Sustained throughput is bounded by the one-sample-per-cycle
// output port. Configuration takes effect on the next byte; write it only while the
// decoder is idle. No clearing pass is needed after reset.
module ima_adpcm_block_decoder
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // chunk_last
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] pcm_sample
    output logic [0:0]  m_axis_tuser,   // [0] sample_channel
    output logic        m_axis_tlast    // run_last
);

    // configuration
    logic [1:0]  channel_count_reg;
    logic [15:0] block_align_reg;

    // input register
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;

    // decoder state
    logic [15:0]        block_offset_reg, block_offset_next;
    logic [2:0]         group_offset_reg, group_offset_next;
    logic signed [15:0] predictor_reg [2];
    logic signed [15:0] predictor_next [2];
    logic [6:0]         step_position_reg [2];
    logic [6:0]         step_position_next [2];
    logic [7:0]         header_low_byte_reg, header_low_byte_next;

    // left sample buffer: one row per left byte, {second, first} sample
    logic [31:0] left_mem [4];
    logic [31:0] left_rd_reg;
    logic        left_wr;

    // decode path
    logic               stereo;
    logic [15:0]        hdr_len;
    logic               is_header;
    logic               hdr_ch;
    logic               right_byte;
    logic               dec_ch;
    logic [2:0]         n_results;
    logic               fire;
    logic [15:0]        hdr_word;
    logic [6:0]         hdr_step;
    logic signed [15:0] s0, s1;
    logic [6:0]         idx0, idx1;

    imadec_pkg::buf_load_t       buf_ctrl;
    imadec_pkg::out_item_t [3:0] load_items;
    imadec_pkg::out_item_t       head_item;
    logic                        buf_can_load;

    // ---------------------------------------------------------------- configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channel_count_reg <= 2'd1;
            block_align_reg   <= 16'd256;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                imadec_pkg::REG_CHANNEL_COUNT: channel_count_reg <= cfg_wdata[1:0];
                imadec_pkg::REG_BLOCK_ALIGN:   block_align_reg   <= cfg_wdata;
                default:                       channel_count_reg <= channel_count_reg;
            endcase
        end
    end

    // ---------------------------------------------------------------- input register
    // Hold the byte until it has been decoded; refill in the cycle it moves on.
    assign s_axis_tready = !in_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    // ---------------------------------------------------------------- classify byte
    assign stereo     = (channel_count_reg == imadec_pkg::CHANNELS_STEREO);
    assign hdr_len    = stereo ? imadec_pkg::HDR_LEN_STEREO : imadec_pkg::HDR_LEN_MONO;
    assign is_header  = (block_offset_reg < hdr_len);
    assign hdr_ch     = block_offset_reg[2];
    assign right_byte = stereo && group_offset_reg[2];
    assign dec_ch     = right_byte;

    always_comb
    begin
        if (is_header)
            n_results = 3'd0;
        else if (!stereo)
            n_results = 3'd2;
        else if (right_byte)
            n_results = 3'd4;
        else
            n_results = 3'd0;
    end

    // A byte that gives no samples never waits on the result buffer.
    assign fire = in_valid_reg && ((n_results == 3'd0) || buf_can_load);

    // ---------------------------------------------------------------- nibble decode
    imadec_nibble u_nib_low
    (
        .pred_in  (predictor_reg[dec_ch]),
        .idx_in   (step_position_reg[dec_ch]),
        .nib      (in_byte_reg[3:0]),
        .pred_out (s0),
        .idx_out  (idx0)
    );

    imadec_nibble u_nib_high
    (
        .pred_in  (s0),
        .idx_in   (idx0),
        .nib      (in_byte_reg[7:4]),
        .pred_out (s1),
        .idx_out  (idx1)
    );

    // ---------------------------------------------------------------- header word
    assign hdr_word = {in_byte_reg, header_low_byte_reg};

    always_comb
    begin
        if (hdr_word[15])
            hdr_step = 7'd0;
        else if (hdr_word > {9'd0, imadec_pkg::MAX_STEP_INDEX})
            hdr_step = imadec_pkg::MAX_STEP_INDEX;
        else
            hdr_step = hdr_word[6:0];
    end

    // ---------------------------------------------------------------- state update
    always_comb
    begin
        block_offset_next    = block_offset_reg;
        group_offset_next    = group_offset_reg;
        predictor_next       = predictor_reg;
        step_position_next   = step_position_reg;
        header_low_byte_next = header_low_byte_reg;
        left_wr              = 1'b0;

        if (fire)
        begin
            if (is_header)
            begin
                // byte order within a channel header: pred lo, pred hi, step lo, step hi
                if (!block_offset_reg[0])
                    header_low_byte_next = in_byte_reg;
                else if (!block_offset_reg[1])
                    predictor_next[hdr_ch] = $signed(hdr_word);
                else
                    step_position_next[hdr_ch] = hdr_step;
            end
            else
            begin
                predictor_next[dec_ch]     = s1;
                step_position_next[dec_ch] = idx1;
                group_offset_next          = group_offset_reg + 3'd1;
                left_wr                    = stereo && !group_offset_reg[2];
            end

            // restart the block after its last byte or at end of chunk
            if (in_last_reg || (({1'b0, block_offset_reg} + 17'd1) >= {1'b0, block_align_reg}))
            begin
                block_offset_next = 16'd0;
                group_offset_next = 3'd0;
            end
            else
            begin
                block_offset_next = block_offset_reg + 16'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_offset_reg     <= 16'd0;
            group_offset_reg     <= 3'd0;
            predictor_reg[0]     <= 16'sd0;
            predictor_reg[1]     <= 16'sd0;
            step_position_reg[0] <= 7'd0;
            step_position_reg[1] <= 7'd0;
            header_low_byte_reg  <= 8'd0;
        end
        else
        begin
            block_offset_reg    <= block_offset_next;
            group_offset_reg    <= group_offset_next;
            predictor_reg       <= predictor_next;
            step_position_reg   <= step_position_next;
            header_low_byte_reg <= header_low_byte_next;
        end
    end

    // ---------------------------------------------------------------- left buffer
    // Read ahead at the row the next byte will use; right byte j reads row j, and the
    // low two group bits of a right byte equal j. A row is written at least four
    // decoded bytes before it is read, never in the cycle it is fetched.
    always_ff @(posedge clk)
    begin
        if (left_wr)
            left_mem[group_offset_reg[1:0]] <= {s1, s0};
        left_rd_reg <= left_mem[group_offset_next[1:0]];
    end

    // ---------------------------------------------------------------- result buffer
    always_comb
    begin
        buf_ctrl.load  = fire && (n_results != 3'd0);
        buf_ctrl.count = n_results;

        if (right_byte)
        begin
            load_items[0] = '{pcm_sample: $signed(left_rd_reg[15:0]),
                              sample_channel: 1'b0, run_last: 1'b0};
            load_items[1] = '{pcm_sample: s0, sample_channel: 1'b1, run_last: 1'b0};
            load_items[2] = '{pcm_sample: $signed(left_rd_reg[31:16]),
                              sample_channel: 1'b0, run_last: 1'b0};
            load_items[3] = '{pcm_sample: s1, sample_channel: 1'b1, run_last: 1'b1};
        end
        else
        begin
            load_items[0] = '{pcm_sample: s0, sample_channel: 1'b0, run_last: 1'b0};
            load_items[1] = '{pcm_sample: s1, sample_channel: 1'b0, run_last: 1'b1};
            load_items[2] = '{pcm_sample: s1, sample_channel: 1'b0, run_last: 1'b1};
            load_items[3] = '{pcm_sample: s1, sample_channel: 1'b0, run_last: 1'b1};
        end
    end

    imadec_outbuf u_outbuf
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (buf_ctrl),
        .load_items (load_items),
        .can_load   (buf_can_load),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_item   (head_item)
    );

    assign m_axis_tdata    = head_item.pcm_sample;
    assign m_axis_tuser[0] = head_item.sample_channel;
    assign m_axis_tlast    = head_item.run_last;

endmodule

/* rtl/imadec_checker.sv */
// Port-level checker for the IMA ADPCM block decoder, bound to the top level.
// Depends on ima_adpcm_block_decoder_defines.svh (assertion macros).
`include "ima_adpcm_block_decoder_defines.svh"

module imadec_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,
    input  logic        s_axis_tlast,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [15:0] m_axis_tdata,
    input  logic [0:0]  m_axis_tuser,
    input  logic        m_axis_tlast
);

    // a stalled output word holds
    `IMADEC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "output word changed while stalled")

    // the rest of a byte's samples are already buffered
    `IMADEC_ASSERT_NEXT(a_run_continues, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid, "gap inside the samples of one byte")

    // in a stereo run a right sample that is not last is followed by a left sample
    `IMADEC_ASSERT_NEXT(a_stereo_order, m_axis_tvalid && m_axis_tready && m_axis_tuser[0] && !m_axis_tlast, !m_axis_tuser[0], "stereo samples out of order")

    // the input only stalls behind samples waiting at the output
    `IMADEC_ASSERT_NOW(a_stall_cause, !s_axis_tready, m_axis_tvalid, "input stalled with no output pending")

endmodule

bind ima_adpcm_block_decoder imadec_checker u_imadec_checker (.*);
